// File: rtl/usart_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usart_pkg: shared types and constants for the usart register block
// beat types, action codes, register offsets, flag bits and the tx pattern
// ----------------------------------------------------------------------------
package usart_pkg;

  localparam int REG_WORDS  = 12;
  localparam int BANK_BYTES = REG_WORDS * 4;
  localparam int BANK_BITS  = BANK_BYTES * 8;
  localparam int WORD_BITS  = $clog2(REG_WORDS);

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  localparam logic [1:0] CFG_HAS_TC   = 2'd0;
  localparam logic [1:0] CFG_SECURE   = 2'd1;
  localparam logic [1:0] CFG_WATCH    = 2'd2;

  localparam logic [5:0] OFF_CR1 = 6'h00;
  localparam logic [5:0] OFF_ISR = 6'h1C;
  localparam logic [5:0] OFF_ICR = 6'h20;
  localparam logic [5:0] OFF_RDR = 6'h24;
  localparam logic [5:0] OFF_TDR = 6'h28;

  localparam logic [WORD_BITS-1:0] CR1_WORD = WORD_BITS'(0);
  localparam logic [WORD_BITS-1:0] ISR_WORD = WORD_BITS'(7);

  localparam int C_UE     = 0;
  localparam int C_RE     = 2;
  localparam int C_TE     = 3;
  localparam int C_RXNEIE = 5;
  localparam int C_TXEIE  = 7;

  localparam int S_RXNE  = 5;
  localparam int S_TC    = 6;
  localparam int S_TXE   = 7;
  localparam int S_TEACK = 21;
  localparam int S_REACK = 22;

  localparam logic [31:0] ISR_RESET = 32'h0000_0080;
  localparam logic [3:0]  PAT_LEN   = 4'd13;

  typedef struct packed {
    action_t     action;
    logic [5:0]  byte_offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;
    logic        nonsecure_access;
    logic        clock_enabled;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        tx_drained;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_ok;
    logic        tx_valid;
    logic [7:0]  tx_data;
    logic        irq_request;
    logic        pattern_hit;
  } out_beat_t;

  function automatic logic [7:0] pattern_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h6D;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h63;
      4'd3:    c = 8'h72;
      4'd4:    c = 8'h6F;
      4'd5:    c = 8'h20;
      4'd6:    c = 8'h20;
      4'd7:    c = 8'h20;
      4'd8:    c = 8'h65;
      4'd9:    c = 8'h72;
      4'd10:   c = 8'h72;
      4'd11:   c = 8'h6F;
      4'd12:   c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] size_mask(input logic [2:0] size);
    logic [31:0] m;
    case (size)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/usart_register_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usart_register_block: serial port register interface with status flags
// bus reads, bus writes and poll ticks against a small register bank
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_ready is high and returns one result beat
// per input beat. The beat is captured in an input register, then the register
// bank, flags, receive holding byte and pattern matcher are updated and the
// result is captured in the output register at the same edge. Both stages
// advance together whenever the output register is empty or its beat is taken,
// so a stalled output holds at most two beats in flight. Configuration writes
// take effect at once and are expected only while no beat is in flight.
module usart_register_block (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  usart_pkg::in_beat_t   in_beat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output usart_pkg::out_beat_t  out_beat,
  input  logic                  cfg_write_en,
  input  logic [1:0]            cfg_index,
  input  logic                  cfg_data
);
  import usart_pkg::*;

  logic        has_tc;
  logic        sec_lock;
  logic        watch_pattern;

  logic [31:0] bank [REG_WORDS];
  logic [31:0] bank_next [REG_WORDS];
  logic        enabled;
  logic        enabled_next;
  logic        rx_full;
  logic        rx_full_next;
  logic [7:0]  rx_holding;
  logic [7:0]  rx_holding_next;
  logic [3:0]  pattern_matched;
  logic [3:0]  pattern_matched_next;

  logic        s1_valid;
  in_beat_t    s1_beat;
  out_beat_t   result;
  logic        advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  function automatic logic [31:0] ready_flags(input logic [31:0] isr, input logic tc);
    logic [31:0] v;
    v = isr;
    v[S_TXE] = 1'b1;
    if (tc) begin
      v[S_TC] = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [31:0] ack_flags(input logic [31:0] isr, input logic [31:0] cr1,
                                            input logic clk_on);
    logic [31:0] v;
    v = isr;
    v[S_TEACK] = clk_on && cr1[C_UE] && cr1[C_TE];
    v[S_REACK] = clk_on && cr1[C_UE] && cr1[C_RE];
    return v;
  endfunction

  always_comb begin : proc_step
    logic                 ue;
    logic                 refused;
    logic [6:0]           span;
    logic [6:0]           rel;
    logic [BANK_BITS-1:0] flat;
    logic [BANK_BITS-1:0] shifted;
    logic [31:0]          wshift;
    logic [7:0]           ch;
    bank_next            = bank;
    enabled_next         = enabled;
    rx_full_next         = rx_full;
    rx_holding_next      = rx_holding;
    pattern_matched_next = pattern_matched;
    result               = '0;
    flat                 = '0;
    shifted              = '0;
    wshift               = '0;
    rel                  = '0;
    ch                   = s1_beat.write_data[7:0];
    ue      = bank[CR1_WORD][C_UE] && s1_beat.clock_enabled;
    span    = {1'b0, s1_beat.byte_offset} + {4'b0000, s1_beat.access_size};
    refused = (s1_beat.access_size == 3'd0) || (s1_beat.access_size > 3'd4) ||
              (span > 7'(BANK_BYTES));
    case (s1_beat.action)
      ACT_READ, ACT_WRITE: begin
        if (sec_lock && s1_beat.nonsecure_access) begin
          result.access_ok = 1'b1;
        end else if (refused) begin
          result.access_ok = 1'b0;
        end else if (s1_beat.action == ACT_READ) begin
          result.access_ok = 1'b1;
          if (ue && !enabled) begin
            bank_next[ISR_WORD] = ready_flags(bank_next[ISR_WORD], has_tc);
          end
          enabled_next = ue;
          if (s1_beat.byte_offset == OFF_RDR) begin
            result.read_data = rx_full ? {24'h0, rx_holding} : 32'h0;
            rx_full_next = 1'b0;
            bank_next[ISR_WORD][S_RXNE] = 1'b0;
          end else begin
            if (s1_beat.byte_offset == OFF_ISR) begin
              bank_next[ISR_WORD] = ack_flags(ready_flags(bank_next[ISR_WORD], has_tc),
                                              bank_next[CR1_WORD], s1_beat.clock_enabled);
            end
            for (int w = 0; w < REG_WORDS; w++) begin
              flat[w*32 +: 32] = bank_next[w];
            end
            shifted = flat >> {s1_beat.byte_offset, 3'b000};
            result.read_data = shifted[31:0] & size_mask(s1_beat.access_size);
          end
        end else begin
          result.access_ok = 1'b1;
          if (s1_beat.byte_offset == OFF_TDR) begin
            if (ue && !enabled) begin
              bank_next[ISR_WORD] = ready_flags(bank_next[ISR_WORD], has_tc);
            end
            enabled_next = ue;
            if (ue) begin
              if (watch_pattern) begin
                if (pattern_matched < PAT_LEN && ch == pattern_char(pattern_matched)) begin
                  if (pattern_matched + 4'd1 == PAT_LEN) begin
                    pattern_matched_next = 4'd0;
                    result.pattern_hit   = 1'b1;
                  end else begin
                    pattern_matched_next = pattern_matched + 4'd1;
                  end
                end else if (ch == pattern_char(4'd0)) begin
                  pattern_matched_next = 4'd1;
                end else begin
                  pattern_matched_next = 4'd0;
                end
              end
              result.tx_valid = 1'b1;
              result.tx_data  = ch;
              bank_next[ISR_WORD][S_TXE] = 1'b0;
              if (has_tc) begin
                bank_next[ISR_WORD][S_TC] = 1'b0;
              end
            end
          end else if (has_tc && s1_beat.byte_offset == OFF_ICR) begin
            if (s1_beat.write_data[S_TC]) begin
              bank_next[ISR_WORD][S_TC] = 1'b0;
            end
          end else begin
            for (int w = 0; w < REG_WORDS; w++) begin
              flat[w*32 +: 32] = bank[w];
            end
            for (int b = 0; b < BANK_BYTES; b++) begin
              if (7'(b) >= {1'b0, s1_beat.byte_offset} && 7'(b) < span) begin
                rel    = 7'(b) - {1'b0, s1_beat.byte_offset};
                wshift = s1_beat.write_data >> {rel[1:0], 3'b000};
                flat[b*8 +: 8] = wshift[7:0];
              end
            end
            for (int w = 0; w < REG_WORDS; w++) begin
              bank_next[w] = flat[w*32 +: 32];
            end
            if (s1_beat.byte_offset == OFF_CR1) begin
              bank_next[ISR_WORD] = ack_flags(bank_next[ISR_WORD], bank_next[CR1_WORD],
                                              s1_beat.clock_enabled);
            end
          end
        end
      end
      ACT_TICK: begin
        result.access_ok = 1'b1;
        if (ue && !enabled) begin
          bank_next[ISR_WORD] = ready_flags(bank_next[ISR_WORD], has_tc);
        end
        enabled_next = ue;
        if (ue) begin
          if (s1_beat.rx_valid) begin
            rx_holding_next = s1_beat.rx_data;
            rx_full_next    = 1'b1;
          end
          if (rx_full_next) begin
            bank_next[ISR_WORD][S_RXNE] = 1'b1;
          end
          if (s1_beat.tx_drained) begin
            bank_next[ISR_WORD] = ready_flags(bank_next[ISR_WORD], has_tc);
          end
          result.irq_request =
            (bank_next[CR1_WORD][C_RXNEIE] && bank_next[ISR_WORD][S_RXNE]) ||
            (bank_next[CR1_WORD][C_TXEIE] && bank_next[ISR_WORD][S_TXE]);
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      has_tc        <= 1'b1;
      sec_lock      <= 1'b0;
      watch_pattern <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_HAS_TC: has_tc        <= cfg_data;
        CFG_SECURE: sec_lock      <= cfg_data;
        CFG_WATCH:  watch_pattern <= cfg_data;
        default: ;
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < REG_WORDS; w++) begin
        bank[w] <= (WORD_BITS'(w) == ISR_WORD) ? ISR_RESET : 32'h0;
      end
      enabled         <= 1'b0;
      rx_full         <= 1'b0;
      rx_holding      <= 8'h00;
      pattern_matched <= 4'd0;
    end else if (advance) begin
      bank            <= bank_next;
      enabled         <= enabled_next;
      rx_full         <= rx_full_next;
      rx_holding      <= rx_holding_next;
      pattern_matched <= pattern_matched_next;
    end
  end

  // input and output stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_beat <= in_beat;
    end
    if (advance) begin
      out_beat <= result;
    end
  end

  a_matcher_range: assert property (@(posedge clk) disable iff (rst)
    pattern_matched < PAT_LEN)
    else $error("pattern matcher out of range");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result beat lost");

  a_hit_needs_tx: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.pattern_hit |-> out_beat.tx_valid && out_beat.access_ok)
    else $error("pattern hit without transmitted byte");

  a_stall_keeps_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_beat))
    else $error("stalled beat dropped");

endmodule
